### rtl/core/mcc_pkg.sv
// Shared types and codes for the migratory coherence controller.
package mcc_pkg;

  // Default geometry
  localparam int unsigned NprocDefault    = 16;
  localparam int unsigned AddrBitsDefault = 48;
  localparam int unsigned QueueDepth      = 4;

  // Input modes
  localparam logic [2:0] MODE_SNOOP_RD  = 3'd0;
  localparam logic [2:0] MODE_SNOOP_RDX = 3'd1;
  localparam logic [2:0] MODE_ACK       = 3'd2;
  localparam logic [2:0] MODE_DATA      = 3'd3;
  localparam logic [2:0] MODE_LOCAL_RD  = 3'd4;
  localparam logic [2:0] MODE_LOCAL_WR  = 3'd5;
  localparam logic [2:0] MODE_TICK      = 3'd6;

  // Line states
  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_S  = 3'd1;
  localparam logic [2:0] ST_E  = 3'd2;
  localparam logic [2:0] ST_D  = 3'd3;
  localparam logic [2:0] ST_S2 = 3'd4;
  localparam logic [2:0] ST_MC = 3'd5;
  localparam logic [2:0] ST_MD = 3'd6;

  // Result kinds
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_ACK   = 3'd1;
  localparam logic [2:0] K_DATA  = 3'd2;
  localparam logic [2:0] K_RD    = 3'd3;
  localparam logic [2:0] K_RDX   = 3'd4;
  localparam logic [2:0] K_DONE  = 3'd5;
  localparam logic [2:0] K_DEFER = 3'd6;

  // Pending request kinds
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_RD   = 2'd1;
  localparam logic [1:0] PEND_WR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIG_EN = 2'd0;
  localparam logic [1:0] CFG_OWN_ID = 2'd1;
  localparam logic [1:0] CFG_MEM_ID = 2'd2;

  typedef struct packed {
    logic       mig_en;
    logic [4:0] own_id;
    logic [4:0] mem_id;
  } cfg_t;

  // One queued job; an ack with transmit set expands into ack plus data
  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] target;
    logic       fs;
    logic       fm;
    logic       ft;
    logic       lw;
    logic [2:0] nls;
    logic       inv;
    logic       rel;
  } job_t;

endpackage

### rtl/core/mcc_front.sv
// Front end: classify each transaction, update the pending request, build a job.
module mcc_front import mcc_pkg::*; #(
  parameter int unsigned NPROC     = NprocDefault,
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 accept_i,
  input  logic [2:0]           mode_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [4:0]           sender_i,
  input  logic [4:0]           receiver_i,
  input  logic                 line_found_i,
  input  logic [2:0]           line_state_i,
  input  logic                 line_most_recent_i,
  input  logic                 ack_shared_i,
  input  logic                 ack_migratory_i,
  input  logic                 hit_conflict_i,
  input  logic [4:0]           ack_count_i,
  input  logic                 table_conflict_i,
  output logic                 push_o,
  output job_t                 job_o,
  output logic [ADDR_BITS-1:0] job_addr_o
);

  localparam int unsigned AckW = $clog2(NPROC);

  logic [1:0]           pend_kind_q, pend_kind_d;
  logic [ADDR_BITS-1:0] pend_addr_q, pend_addr_d;
  logic [AckW-1:0]      acks_q, acks_d;
  logic                 got_data_q, got_data_d;
  logic                 seen_sh_q, seen_sh_d;
  logic                 seen_mig_q, seen_mig_d;
  logic                 wait_q, wait_d;

  logic            found, recent, own_msg, match, pend_valid, mflag;
  logic [AckW-1:0] acks_clamped;
  logic            do_issue;
  logic [1:0]      issue_kind;
  logic [ADDR_BITS-1:0] issue_addr;
  logic [2:0]      done_state;

  // Decode lookup and message ownership
  assign found   = line_found_i && (line_state_i >= ST_S) && (line_state_i <= ST_MD);
  assign recent  = found && line_most_recent_i;
  assign own_msg = (mode_i <= MODE_DATA) && (sender_i == cfg_i.own_id);
  assign pend_valid = (pend_kind_q == PEND_RD) || (pend_kind_q == PEND_WR);
  assign match   = (pend_kind_q != PEND_NONE) && (addr_i == pend_addr_q)
                   && (receiver_i == cfg_i.own_id);
  assign mflag   = cfg_i.mig_en && seen_mig_q;
  assign acks_clamped = (ack_count_i > 5'(NPROC - 1)) ? AckW'(NPROC - 1)
                                                      : AckW'(ack_count_i);

  // Completion state for a finished request
  always_comb begin
    if (pend_kind_q == PEND_RD) begin
      done_state = mflag ? ST_MC : (seen_sh_q ? ST_S : ST_E);
    end else if (!found) begin
      done_state = mflag ? ST_MD : ST_D;
    end else if ((line_state_i == ST_E) || (line_state_i == ST_S2)) begin
      done_state = ST_D;
    end else if (line_state_i == ST_S) begin
      done_state = mflag ? ST_MD : ST_D;
    end else begin
      done_state = cfg_i.mig_en ? ST_MD : ST_D;
    end
  end

  // Classify the transaction and compute the next pending state
  always_comb begin
    pend_kind_d = pend_kind_q;
    pend_addr_d = pend_addr_q;
    acks_d      = acks_q;
    got_data_d  = got_data_q;
    seen_sh_d   = seen_sh_q;
    seen_mig_d  = seen_mig_q;
    wait_d      = wait_q;
    push_o      = 1'b0;
    job_o       = '0;
    job_addr_o  = addr_i;
    do_issue    = 1'b0;
    issue_kind  = PEND_RD;
    issue_addr  = addr_i;

    if (!own_msg) begin
      unique case (mode_i) inside
        MODE_SNOOP_RD, MODE_SNOOP_RDX: begin
          push_o       = 1'b1;
          job_o.target = sender_i;
          if (hit_conflict_i) begin
            job_o.kind = K_DEFER;
          end else begin
            job_o.kind = K_ACK;
            job_o.ft   = recent;
            if (found) begin
              job_o.lw = 1'b1;
              if (mode_i == MODE_SNOOP_RD) begin
                unique case (line_state_i) inside
                  ST_S, ST_S2: begin
                    job_o.nls = ST_S;
                    job_o.fs  = 1'b1;
                  end
                  ST_E, ST_D, ST_MC: begin
                    job_o.nls = cfg_i.mig_en ? ST_S2 : ST_S;
                    job_o.fs  = 1'b1;
                  end
                  default: begin
                    job_o.nls = ST_I;
                    job_o.fm  = 1'b1;
                    job_o.inv = 1'b1;
                  end
                endcase
              end else begin
                job_o.nls = ST_I;
                job_o.inv = 1'b1;
                job_o.fm  = (line_state_i == ST_MD)
                            || (cfg_i.mig_en && ((line_state_i == ST_E)
                                || (line_state_i == ST_D) || (line_state_i == ST_S2)));
              end
            end
          end
        end
        MODE_ACK: begin
          if (match) begin
            if ((sender_i != cfg_i.mem_id) && (acks_q != '0)) begin
              acks_d = acks_q - AckW'(1);
            end
            if (ack_shared_i) seen_sh_d = 1'b1;
            if (ack_migratory_i) seen_mig_d = 1'b1;
          end
        end
        MODE_DATA: begin
          if (match) got_data_d = 1'b1;
        end
        MODE_LOCAL_RD: begin
          do_issue = 1'b1;
        end
        MODE_LOCAL_WR: begin
          do_issue   = 1'b1;
          issue_kind = PEND_WR;
        end
        MODE_TICK: begin
          if (wait_q) begin
            if (!table_conflict_i) begin
              if (pend_valid) begin
                do_issue   = 1'b1;
                issue_kind = pend_kind_q;
                issue_addr = pend_addr_q;
              end else begin
                wait_d = 1'b0;
              end
            end
          end else if (pend_valid && (acks_q == '0) && got_data_q) begin
            push_o      = 1'b1;
            job_o.kind  = K_DONE;
            job_o.lw    = 1'b1;
            job_o.nls   = done_state;
            job_o.rel   = 1'b1;
            job_addr_o  = pend_addr_q;
            pend_kind_d = PEND_NONE;
            wait_d      = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // Start or restart the pending request
    if (do_issue) begin
      push_o      = 1'b1;
      job_addr_o  = issue_addr;
      pend_kind_d = issue_kind;
      pend_addr_d = issue_addr;
      acks_d      = acks_clamped;
      got_data_d  = 1'b0;
      seen_sh_d   = 1'b0;
      seen_mig_d  = 1'b0;
      wait_d      = table_conflict_i;
      if (table_conflict_i) begin
        job_o.kind = K_DEFER;
      end else begin
        job_o.kind = (issue_kind == PEND_RD) ? K_RD : K_RDX;
      end
    end

    if (!accept_i) begin
      push_o = 1'b0;
    end
  end

  // Hold pending request state; advance on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_kind_q <= PEND_NONE;
      pend_addr_q <= '0;
      acks_q      <= '0;
      got_data_q  <= 1'b0;
      seen_sh_q   <= 1'b0;
      seen_mig_q  <= 1'b0;
      wait_q      <= 1'b0;
    end else if (accept_i) begin
      pend_kind_q <= pend_kind_d;
      pend_addr_q <= pend_addr_d;
      acks_q      <= acks_d;
      got_data_q  <= got_data_d;
      seen_sh_q   <= seen_sh_d;
      seen_mig_q  <= seen_mig_d;
      wait_q      <= wait_d;
    end
  end

endmodule

### rtl/core/mcc_queue.sv
// Job queue between the front end and the result sequencer.
module mcc_queue import mcc_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  job_t                 push_job_i,
  input  logic [ADDR_BITS-1:0] push_addr_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 not_empty_o,
  output job_t                 head_job_o,
  output logic [ADDR_BITS-1:0] head_addr_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t                 job_mem [QueueDepth];
  logic [ADDR_BITS-1:0] addr_mem [QueueDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_job_o  = job_mem[rd_q];
  assign head_addr_o = addr_mem[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      job_mem[wr_q]  <= push_job_i;
      addr_mem[wr_q] <= push_addr_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop) rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/mcc_back.sv
// Result sequencer: expand queued jobs into result transactions behind an output register.
module mcc_back import mcc_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 not_empty_i,
  input  job_t                 head_job_i,
  input  logic [ADDR_BITS-1:0] head_addr_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output job_t                 out_job_o,
  output logic [ADDR_BITS-1:0] out_addr_o,
  output logic                 out_last_o
);

  logic                 valid_q, valid_d;
  logic                 phase_q, phase_d;
  job_t                 job_q, job_d;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 last_q, last_d;
  logic                 load;

  assign load = !valid_q || !out_stall_i;

  // Pick the next result: the job itself, then its data broadcast if any
  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    job_d   = job_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = not_empty_i;
      if (not_empty_i) begin
        if (phase_q) begin
          job_d        = '0;
          job_d.kind   = K_DATA;
          job_d.target = head_job_i.target;
          last_d       = 1'b1;
          pop_o        = 1'b1;
          phase_d      = 1'b0;
        end else if ((head_job_i.kind == K_ACK) && head_job_i.ft) begin
          job_d   = head_job_i;
          last_d  = 1'b0;
          phase_d = 1'b1;
        end else begin
          job_d  = head_job_i;
          last_d = 1'b1;
          pop_o  = 1'b1;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Hold result payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q  <= job_d;
      addr_q <= head_addr_i;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_job_o   = job_q;
  assign out_addr_o  = addr_q;
  assign out_last_o  = last_q;

endmodule

### rtl/core/migratory_coherence_controller.sv
// Top level of the migratory coherence controller.
//
// Usage: one controller per processor. The input channel (in_valid_i / in_stall_o)
// carries snoops, acks, data, local requests and ticks; the output channel
// (out_valid_o / out_stall_i) carries result transactions, with last_o on the
// final result of each input transaction. Acks, data and dropped messages
// give no result; a snoop whose copy is most recent and that is not deferred
// gives an ack followed by a data broadcast.
// Throughput: one input transaction per cycle while in_stall_o is low. Output
// bandwidth is one result per cycle while out_stall_i is low, so a snoop with
// data broadcast puts two results on the output. Path: the front end writes a
// job into a 4-entry queue, and the sequencer moves it from the queue to the
// output register.
// Stall: if out_stall_i holds, the output register keeps its result, the queue
// fills and in_stall_o rises once all 4 entries are used.
// Reset: rst_ni clears the pending request, empties the queue and restores the
// register defaults (migration enabled, own id 0, memory id 31).
// Write cfg_we_i / cfg_idx_i / cfg_wdata_i only while no transaction is in flight.
module migratory_coherence_controller import mcc_pkg::*; #(
  parameter int unsigned NPROC     = NprocDefault,
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           mode_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [4:0]           sender_i,
  input  logic [4:0]           receiver_i,
  input  logic                 line_found_i,
  input  logic [2:0]           line_state_i,
  input  logic                 line_most_recent_i,
  input  logic                 ack_shared_i,
  input  logic                 ack_migratory_i,
  input  logic                 hit_conflict_i,
  input  logic [4:0]           ack_count_i,
  input  logic                 table_conflict_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           kind_o,
  output logic [ADDR_BITS-1:0] out_addr_o,
  output logic [4:0]           target_o,
  output logic                 flag_shared_o,
  output logic                 flag_migratory_o,
  output logic                 flag_transmit_o,
  output logic                 line_write_o,
  output logic [2:0]           new_line_state_o,
  output logic                 invalidate_o,
  output logic                 release_entry_o,
  output logic                 last_o
);

  cfg_t                 cfg_q;
  logic                 accept, push, pop, full, not_empty;
  job_t                 push_job, head_job, out_job;
  logic [ADDR_BITS-1:0] push_addr, head_addr;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mig_en <= 1'b1;
      cfg_q.own_id <= 5'd0;
      cfg_q.mem_id <= 5'd31;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIG_EN: cfg_q.mig_en <= cfg_wdata_i[0];
        CFG_OWN_ID: cfg_q.own_id <= cfg_wdata_i;
        CFG_MEM_ID: cfg_q.mem_id <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  mcc_front #(
    .NPROC     (NPROC),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .accept_i           (accept),
    .mode_i             (mode_i),
    .addr_i             (addr_i),
    .sender_i           (sender_i),
    .receiver_i         (receiver_i),
    .line_found_i       (line_found_i),
    .line_state_i       (line_state_i),
    .line_most_recent_i (line_most_recent_i),
    .ack_shared_i       (ack_shared_i),
    .ack_migratory_i    (ack_migratory_i),
    .hit_conflict_i     (hit_conflict_i),
    .ack_count_i        (ack_count_i),
    .table_conflict_i   (table_conflict_i),
    .push_o             (push),
    .job_o              (push_job),
    .job_addr_o         (push_addr)
  );

  mcc_queue #(
    .ADDR_BITS (ADDR_BITS)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .push_addr_i (push_addr),
    .pop_i       (pop),
    .full_o      (full),
    .not_empty_o (not_empty),
    .head_job_o  (head_job),
    .head_addr_o (head_addr)
  );

  mcc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (not_empty),
    .head_job_i  (head_job),
    .head_addr_i (head_addr),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_job_o   (out_job),
    .out_addr_o  (out_addr_o),
    .out_last_o  (last_o)
  );

  // Break the result out onto its ports
  assign kind_o           = out_job.kind;
  assign target_o         = out_job.target;
  assign flag_shared_o    = out_job.fs;
  assign flag_migratory_o = out_job.fm;
  assign flag_transmit_o  = out_job.ft;
  assign line_write_o     = out_job.lw;
  assign new_line_state_o = out_job.nls;
  assign invalidate_o     = out_job.inv;
  assign release_entry_o  = out_job.rel;

endmodule
